### sv/s2alu_pkg.sv
package s2alu_pkg;

    typedef enum logic [4:0] {
        ACT_ADD_U32  = 5'd0,
        ACT_ADD_I32  = 5'd1,
        ACT_SUB_I32  = 5'd2,
        ACT_MIN_U32  = 5'd3,
        ACT_MAX_I32  = 5'd4,
        ACT_MAX_U32  = 5'd5,
        ACT_CSELECT  = 5'd6,
        ACT_AND32    = 5'd7,
        ACT_AND64    = 5'd8,
        ACT_OR32     = 5'd9,
        ACT_OR64     = 5'd10,
        ACT_XOR64    = 5'd11,
        ACT_ANDN2_64 = 5'd12,
        ACT_NAND64   = 5'd13,
        ACT_LSHL     = 5'd14,
        ACT_LSHR     = 5'd15,
        ACT_ASHR     = 5'd16,
        ACT_MUL      = 5'd17,
        ACT_BFE      = 5'd18
    } action_t;

    localparam int WORD_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int BFE_W_LSB = 16;
    localparam int BFE_W_W   = 7;

    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [6:0]  dest_index;
    } op_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic        result_is_wide;
        logic [6:0]  dest_out;
        logic        scc_value;
        logic        scc_written;
    } res_t;

endpackage

### sv/s2alu_exec.sv
module s2alu_exec
    import s2alu_pkg::*;
(
    input  op_t  op,
    input  logic scc,
    output res_t res
);

    logic [WORD_W-1:0]    a32;
    logic [WORD_W-1:0]    b32;
    logic [SHIFT_W-1:0]   sh;
    logic [WORD_W:0]      sum33;
    logic [WORD_W-1:0]    diff;
    logic [WORD_W-1:0]    shl_v;
    logic [WORD_W-1:0]    shr_v;
    logic [WORD_W-1:0]    asr_v;
    logic [WORD_W-1:0]    mul_v;
    logic [BFE_W_W-1:0]   bfe_w;
    logic [BFE_W_W:0]     bfe_end;
    logic [WORD_W-1:0]    bfe_mask;
    logic                 bfe_sign;
    logic [WORD_W-1:0]    bfe_v;
    logic [63:0]          val;
    logic                 wide;
    logic                 flag;
    logic                 wr;

    assign a32   = op.operand_a[WORD_W-1:0];
    assign b32   = op.operand_b[WORD_W-1:0];
    assign sh    = op.operand_b[SHIFT_W-1:0];
    assign sum33 = {1'b0, a32} + {1'b0, b32};
    assign diff  = a32 - b32;
    assign shl_v = a32 << sh;
    assign shr_v = a32 >> sh;
    assign asr_v = WORD_W'($signed(a32) >>> sh);
    assign mul_v = a32 * b32;

    // bitfield extract: offset shares the shift field
    assign bfe_w    = op.operand_b[BFE_W_LSB +: BFE_W_W];
    assign bfe_end  = {1'b0, bfe_w} + {{(BFE_W_W + 1 - SHIFT_W){1'b0}}, sh};
    assign bfe_mask = (WORD_W'(1) << bfe_w[SHIFT_W-1:0]) - WORD_W'(1);
    assign bfe_sign = asr_v[bfe_w[SHIFT_W-1:0] - SHIFT_W'(1)];

    always_comb
    begin
        if (bfe_w == '0)
            bfe_v = '0;
        else if (bfe_end >= (BFE_W_W + 1)'(WORD_W))
            bfe_v = asr_v;
        else
            bfe_v = (asr_v & bfe_mask) | (bfe_sign ? ~bfe_mask : '0);
    end

    always_comb
    begin
        val  = '0;
        wide = 1'b0;
        flag = 1'b0;
        wr   = 1'b1;
        case (op.action)
            ACT_ADD_U32:
            begin
                val  = {32'd0, sum33[WORD_W-1:0]};
                flag = sum33[WORD_W];
            end
            ACT_ADD_I32:
            begin
                val  = {32'd0, sum33[WORD_W-1:0]};
                flag = (a32[31] == b32[31]) && (sum33[31] != a32[31]);
            end
            ACT_SUB_I32:
            begin
                val  = {32'd0, diff};
                flag = (a32[31] != b32[31]) && (diff[31] != a32[31]);
            end
            ACT_MIN_U32:
            begin
                flag = a32 < b32;
                val  = {32'd0, flag ? a32 : b32};
            end
            ACT_MAX_I32:
            begin
                flag = $signed(b32) < $signed(a32);
                val  = {32'd0, flag ? a32 : b32};
            end
            ACT_MAX_U32:
            begin
                flag = a32 > b32;
                val  = {32'd0, flag ? a32 : b32};
            end
            ACT_CSELECT:
            begin
                val = {32'd0, scc ? a32 : b32};
                wr  = 1'b0;
            end
            ACT_AND32:
            begin
                val  = {32'd0, a32 & b32};
                flag = |(a32 & b32);
            end
            ACT_OR32:
            begin
                val  = {32'd0, a32 | b32};
                flag = |(a32 | b32);
            end
            ACT_AND64:
            begin
                val  = op.operand_a & op.operand_b;
                wide = 1'b1;
                flag = |val;
            end
            ACT_OR64:
            begin
                val  = op.operand_a | op.operand_b;
                wide = 1'b1;
                flag = |val;
            end
            ACT_XOR64:
            begin
                val  = op.operand_a ^ op.operand_b;
                wide = 1'b1;
                flag = |val;
            end
            ACT_ANDN2_64:
            begin
                val  = op.operand_a & ~op.operand_b;
                wide = 1'b1;
                flag = |val;
            end
            ACT_NAND64:
            begin
                val  = ~(op.operand_a & op.operand_b);
                wide = 1'b1;
                flag = |val;
            end
            ACT_LSHL:
            begin
                val  = {32'd0, shl_v};
                flag = |shl_v;
            end
            ACT_LSHR:
            begin
                val  = {32'd0, shr_v};
                flag = |shr_v;
            end
            ACT_ASHR:
            begin
                val  = {32'd0, asr_v};
                flag = |asr_v;
            end
            ACT_MUL:
            begin
                val = {32'd0, mul_v};
                wr  = 1'b0;
            end
            ACT_BFE:
            begin
                val  = {32'd0, bfe_v};
                flag = |bfe_v;
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
    end

    assign res.result_value   = val;
    assign res.result_is_wide = wide;
    assign res.dest_out       = op.dest_index;
    assign res.scc_value      = flag & wr;
    assign res.scc_written    = wr;

endmodule

### sv/scalar_two_operand_alu.sv
// Scalar two-operand ALU holding the condition bit SCC. Every transaction on op is
// registered, evaluated in one combinational pass and registered again on res, and one
// transaction is taken per cycle under no backpressure; the 32x32 multiply and the
// bitfield extract shifters set the longest path. SCC is updated as each flag-writing
// result is registered, so a select reads the flag left by the latest flag-writing
// transaction before it. A stalled res stage holds its result while one more
// transaction waits in the input register.
module scalar_two_operand_alu
    import s2alu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_ready,
    input  op_t  op,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic s1_valid_reg;
    op_t  s1_op_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic condition_bit_reg;
    logic condition_bit_next;
    res_t exec_res;
    logic out_load;

    s2alu_exec u_exec (
        .op  (s1_op_reg),
        .scc (condition_bit_reg),
        .res (exec_res)
    );

    assign out_load = s1_valid_reg && (!out_valid_reg || res_ready);
    assign op_ready = !s1_valid_reg || out_load;

    assign condition_bit_next = (out_load && exec_res.scc_written) ? exec_res.scc_value
                                                                   : condition_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            condition_bit_reg <= 1'b0;
        end
        else
        begin
            if (op_ready)
                s1_valid_reg <= op_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            condition_bit_reg <= condition_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_ready && op_valid)
            s1_op_reg <= op;
        if (out_load)
            out_reg <= exec_res;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // scc moves only when a flag-writing transaction is registered
    assert property (@(posedge clk) disable iff (!rst_n)
        (condition_bit_reg != $past(condition_bit_reg))
            |-> $past(out_load && exec_res.scc_written))
        else $error("condition bit changed without a flag-writing transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.scc_written) |-> (condition_bit_reg == res.scc_value))
        else $error("condition bit disagrees with the pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.result_is_wide) |-> (res.result_value[63:32] == 32'd0))
        else $error("narrow result with nonzero upper word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.result_is_wide) |-> res.scc_written)
        else $error("wide result without a flag update");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import s2alu_pkg::*;

    localparam logic [4:0] ACT_FIRST_UNUSED = 5'd19;
    localparam logic [4:0] ACT_LAST_CODE    = 5'd31;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic op_valid;
    logic op_ready;
    op_t  op;
    logic res_valid;
    logic res_ready;
    res_t res;

    res_t alu_results_due[$];
    logic scc_model;
    bit   traffic_gaps;
    bit   hold_req;
    int   error_count;

    scalar_two_operand_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic res_t alu_compute(input op_t t);
        res_t        r;
        logic [31:0] a32;
        logic [31:0] b32;
        logic [31:0] lo;
        logic [31:0] mask;
        logic [32:0] sum;
        logic [4:0]  sh;
        logic [6:0]  w;
        logic [63:0] v;
        logic        flag;
        logic        wr;
        logic        wide;
        a32  = t.operand_a[31:0];
        b32  = t.operand_b[31:0];
        sh   = b32[SHIFT_W-1:0];
        w    = b32[BFE_W_LSB +: BFE_W_W];
        lo   = '0;
        v    = '0;
        flag = 1'b0;
        wr   = 1'b1;
        wide = 1'b0;
        case (t.action)
            ACT_ADD_U32:
            begin
                sum  = {1'b0, a32} + {1'b0, b32};
                lo   = sum[31:0];
                flag = sum[32];
            end
            ACT_ADD_I32:
            begin
                lo   = a32 + b32;
                flag = (a32[31] == b32[31]) && (lo[31] != a32[31]);
            end
            ACT_SUB_I32:
            begin
                lo   = a32 - b32;
                flag = (a32[31] != b32[31]) && (lo[31] != a32[31]);
            end
            ACT_MIN_U32:
            begin
                flag = a32 < b32;
                lo   = flag ? a32 : b32;
            end
            ACT_MAX_I32:
            begin
                flag = $signed(a32) > $signed(b32);
                lo   = flag ? a32 : b32;
            end
            ACT_MAX_U32:
            begin
                flag = a32 > b32;
                lo   = flag ? a32 : b32;
            end
            ACT_CSELECT:
            begin
                lo = scc_model ? a32 : b32;
                wr = 1'b0;
            end
            ACT_AND32:
            begin
                lo   = a32 & b32;
                flag = |lo;
            end
            ACT_OR32:
            begin
                lo   = a32 | b32;
                flag = |lo;
            end
            ACT_AND64, ACT_OR64, ACT_XOR64, ACT_ANDN2_64, ACT_NAND64:
            begin
                case (t.action)
                    ACT_AND64:    v = t.operand_a & t.operand_b;
                    ACT_OR64:     v = t.operand_a | t.operand_b;
                    ACT_XOR64:    v = t.operand_a ^ t.operand_b;
                    ACT_ANDN2_64: v = t.operand_a & ~t.operand_b;
                    default:      v = ~(t.operand_a & t.operand_b);
                endcase
                wide = 1'b1;
                flag = |v;
            end
            ACT_LSHL:
            begin
                lo   = a32 << sh;
                flag = |lo;
            end
            ACT_LSHR:
            begin
                lo   = a32 >> sh;
                flag = |lo;
            end
            ACT_ASHR:
            begin
                lo   = $signed(a32) >>> sh;
                flag = |lo;
            end
            ACT_MUL:
            begin
                lo = a32 * b32;
                wr = 1'b0;
            end
            ACT_BFE:
            begin
                if (w == '0)
                    lo = '0;
                else if (int'(w) + int'(sh) >= WORD_W)
                    lo = $signed(a32) >>> sh;
                else
                begin
                    mask = (32'd1 << w) - 32'd1;
                    lo   = (a32 >> sh) & mask;
                    if (lo[w - 1])
                        lo = lo | ~mask;
                end
                flag = |lo;
            end
            default:
                wr = 1'b0;
        endcase
        if (!wide)
            v = {32'h0, lo};
        if (wr)
            scc_model = flag;
        else
            flag = 1'b0;
        r.result_value   = v;
        r.result_is_wide = wide;
        r.dest_out       = t.dest_index;
        r.scc_value      = flag;
        r.scc_written    = wr;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(input logic [4:0] act, input logic [63:0] a, input logic [63:0] b);
        op_t item;
        item.action     = act;
        item.operand_a  = a;
        item.operand_b  = b;
        item.dest_index = 7'($urandom());
        if (traffic_gaps && $urandom_range(0, 99) < 21)
        begin
            op_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        op_valid <= 1'b1;
        op       <= item;
        do
            @(posedge clk);
        while (!op_ready);
        alu_results_due.push_back(alu_compute(item));
    endtask

    task automatic send_random_op();
        logic [4:0]  act;
        logic [63:0] a;
        logic [63:0] b;
        if ($urandom_range(0, 9) == 0)
            act = 5'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
        else
            act = 5'($urandom_range(ACT_ADD_U32, ACT_BFE));
        a = {pick_word(), pick_word()};
        b = {pick_word(), pick_word()};
        if ($urandom_range(0, 7) == 0)
            b[31:0] = a[31:0];
        // keep most extract widths in the sign-extending range
        if (act == ACT_BFE && $urandom_range(0, 1) == 1)
            b[BFE_W_LSB +: BFE_W_W] = 7'($urandom_range(0, 32));
        send_op(act, a, b);
    endtask

    task automatic test_directed();
        send_op(ACT_ADD_U32, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_op(ACT_ADD_U32, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000);
        send_op(ACT_ADD_I32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_0000_0001);
        send_op(ACT_ADD_I32, 64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000);
        send_op(ACT_SUB_I32, 64'h0000_0000_8000_0000, 64'h0000_0000_0000_0001);
        send_op(ACT_SUB_I32, 64'h0000_0000_0000_0000, 64'h0000_0000_8000_0000);
        send_op(ACT_MIN_U32, 64'h0000_0000_0000_0005, 64'h0000_0000_0000_0005);
        send_op(ACT_MAX_I32, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_op(ACT_MAX_I32, 64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000);
        send_op(ACT_MAX_U32, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_0000);
        send_op(ACT_CSELECT, 64'h1234_5678_AAAA_AAAA, 64'h8765_4321_5555_5555);
        send_op(ACT_AND32, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(ACT_CSELECT, 64'h1234_5678_AAAA_AAAA, 64'h8765_4321_5555_5555);
        send_op(ACT_AND64, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(ACT_OR32, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_0000_0000);
        send_op(ACT_OR64, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_op(ACT_XOR64, 64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5);
        send_op(ACT_ANDN2_64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0F0F_0F0F_0F0F_0F0F);
        send_op(ACT_NAND64, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(ACT_LSHL, 64'h0000_0000_0000_0003, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(ACT_LSHR, 64'h0000_0000_8000_0000, 64'h0000_0000_0000_0020);
        send_op(ACT_ASHR, 64'h0000_0000_8000_0000, 64'h0000_0000_0000_001F);
        send_op(ACT_MUL, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
        send_op(ACT_BFE, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FF80_FFE4);
        send_op(ACT_BFE, 64'h0000_0000_8765_4321, 64'h0000_0000_000C_0014);
        send_op(ACT_BFE, 64'h0000_0000_0000_0F80, 64'h0000_0000_0008_0004);
        send_op(ACT_FIRST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(ACT_LAST_CODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    endtask

    task automatic test_random();
        repeat (1100) send_random_op();
    endtask

    task automatic test_back_to_back();
        traffic_gaps = 1'b0;
        repeat (150) send_random_op();
        traffic_gaps = 1'b1;
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        repeat (40) send_random_op();
    endtask

    // receiver side
    initial
    begin
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            res_ready <= traffic_gaps ? ($urandom_range(0, 99) >= 21) : 1'b1;
        end
    end

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (alu_results_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, res);
                error_count++;
            end
            else
            begin
                want = alu_results_due.pop_front();
                report_field("result_value", want.result_value, res.result_value);
                report_field("result_is_wide", want.result_is_wide, res.result_is_wide);
                report_field("dest_out", want.dest_out, res.dest_out);
                report_field("scc_value", want.scc_value, res.scc_value);
                report_field("scc_written", want.scc_written, res.scc_written);
            end
        end
    end

    initial
    begin
        error_count  = 0;
        scc_model    = 1'b0;
        traffic_gaps = 1'b1;
        hold_req     = 1'b0;
        rst_n    <= 1'b0;
        op_valid <= 1'b0;
        op       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_back_to_back();
        test_output_stall();

        op_valid <= 1'b0;
        while (alu_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
